/* sv/esf_pkg.sv */
// shared types and constants of the frame echo suppressor
// no dependencies; every other file uses it
package esf_pkg;

  localparam int SampleW  = 16;
  localparam int GainW    = 15;
  localparam int LenW     = 7;
  localparam int EnergyW  = 40;
  localparam int LevelW   = 24;
  localparam int NumW     = 56;  // energy << 16, dividend of the mean
  localparam int RmsW     = 28;  // root of a NumW-bit radicand
  localparam int DivCntW  = 6;
  localparam int SqrtCntW = 5;
  localparam int ProdW    = 32;
  localparam int CfgIdxW  = 2;

  localparam logic [GainW-1:0]  GainReset  = 15'd26214;
  localparam logic [GainW-1:0]  RateReset  = 15'd328;
  localparam logic [GainW-1:0]  QuietScale = 15'd3277;
  localparam logic [GainW-1:0]  SpeechGain = 15'd9830;
  localparam logic [LevelW-1:0] LevelReset = 24'd256000;
  localparam logic [RmsW-1:0]   RmsActive  = 28'd25600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN = 2'd0,
    CFG_RATE = 2'd1
  } cfg_reg_e;

  // commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic div_run;
    logic sqrt_load;
    logic sqrt_run;
    logic lvl_mul;
    logic lvl_upd;
    logic cap_decide;
    logic emit_rd;
    logic emit_mul;
    logic emit_fin;
    logic out_valid;
    logic emit_next;
    logic emit_done;
  } esf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic beat_end;
    logic beat_cap;
    logic echo_empty;
    logic div_done;
    logic sqrt_done;
    logic src_cap;
    logic emit_last;
    logic out_taken;
  } esf_sts_t;

endpackage

/* sv/esf_if.sv */
// valid/ready channel interfaces for input samples and output samples
// depends on esf_pkg for field widths
interface esf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [esf_pkg::SampleW-1:0]  in_sample;
  logic                                in_last;
  modport source (output valid, output cmd, output in_sample, output in_last, input ready);
  modport sink   (input valid, input cmd, input in_sample, input in_last, output ready);
endinterface

interface esf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [esf_pkg::SampleW-1:0]  out_sample;
  logic                                out_last;
  modport source (output valid, output out_sample, output out_last, input ready);
  modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

/* sv/esf_ctrl.sv */
// controller state machine of the frame echo suppressor
// depends on esf_pkg for the command and status structs
module esf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esf_pkg::esf_sts_t sts_i,
  output esf_pkg::esf_cmd_t cmd_o
);
  import esf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV      = 9'b000000010,
    S_SQRT     = 9'b000000100,
    S_LVL_MUL  = 9'b000001000,
    S_LVL_UPD  = 9'b000010000,
    S_EMIT_RD  = 9'b000100000,
    S_EMIT_MUL = 9'b001000000,
    S_EMIT_FIN = 9'b010000000,
    S_EMIT_OUT = 9'b100000000
  } state_e;

  state_e   state_q, state_d;
  esf_cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts_i.beat_end) begin
          if (sts_i.beat_cap && sts_i.echo_empty) state_d = S_EMIT_RD;
          else                                    state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd.sqrt_load = 1'b1;
          state_d       = S_SQRT;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          if (sts_i.src_cap) begin
            cmd.cap_decide = 1'b1;
            state_d        = S_EMIT_RD;
          end else begin
            state_d = S_LVL_MUL;
          end
        end else begin
          cmd.sqrt_run = 1'b1;
        end
      end
      S_LVL_MUL: begin
        cmd.lvl_mul = 1'b1;
        state_d     = S_LVL_UPD;
      end
      S_LVL_UPD: begin
        cmd.lvl_upd = 1'b1;
        state_d     = S_IDLE;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_d     = S_EMIT_MUL;
      end
      S_EMIT_MUL: begin
        cmd.emit_mul = 1'b1;
        state_d      = S_EMIT_FIN;
      end
      S_EMIT_FIN: begin
        cmd.emit_fin = 1'b1;
        state_d      = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.out_valid = 1'b1;
        if (sts_i.out_taken) begin
          if (sts_i.emit_last) begin
            cmd.emit_done = 1'b1;
            state_d       = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_d       = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign cmd_o = cmd;

endmodule

/* sv/esf_dp.sv */
// datapath: echo fifo, capture buffer, mean divider, square root, level and emit math
// depends on esf_pkg and the channel interfaces in esf_if.sv
module esf_dp #(
  parameter int ECHO_DEPTH = 4096,
  parameter int FRAME_MAX  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  esf_in_if.sink                         in_i,
  esf_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [esf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [esf_pkg::GainW-1:0]      cfg_data_i,
  input  esf_pkg::esf_cmd_t              cmd_i,
  output esf_pkg::esf_sts_t              sts_o
);
  import esf_pkg::*;

  localparam int AW  = $clog2(ECHO_DEPTH);
  localparam int CW  = $clog2(ECHO_DEPTH + 1);
  localparam int CIW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(ECHO_DEPTH)) sum = sum - (AW+1)'(ECHO_DEPTH);
    return sum[AW-1:0];
  endfunction

  // configuration and control state
  logic [GainW-1:0]   gain_q, rate_q;
  logic [AW-1:0]      head_q;
  logic [CW-1:0]      count_q;
  logic [LevelW-1:0]  level_q;
  logic [LenW-1:0]    cap_len_q, pb_len_q, n_q;
  logic [EnergyW-1:0] cap_e_q, pb_e_q;
  logic               quiet_q, src_cap_q;
  logic [CIW-1:0]     idx_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [SqrtCntW-1:0] scnt_q;

  // payload registers
  logic [NumW-1:0]        num_q, rad_q;
  logic [LenW-1:0]        dlen_q;
  logic [LenW-1:0]        rem_q;
  logic [RmsW-1:0]        root_q;
  logic [RmsW+1:0]        srem_q;
  logic [GainW+RmsW-1:0]  p1_q;
  logic signed [SampleW-1:0] cap_rd_q, fifo_rd_q, out_sample_q;
  logic signed [ProdW-1:0]   prod_q;
  logic                      out_last_q;

  logic signed [SampleW-1:0] fifo_mem [ECHO_DEPTH];
  logic signed [SampleW-1:0] cap_mem  [FRAME_MAX];

  // input beat
  logic                      beat, closes, full;
  logic signed [2*SampleW-1:0] sq_s;
  logic [LenW-1:0]           len_new;
  logic [EnergyW-1:0]        e_new;
  logic [AW-1:0]             push_addr;

  assign beat      = in_i.valid && cmd_i.in_ready;
  assign sq_s      = in_i.in_sample * in_i.in_sample;
  assign len_new   = (in_i.cmd ? cap_len_q : pb_len_q) + LenW'(1);
  assign e_new     = (in_i.cmd ? cap_e_q : pb_e_q) + EnergyW'(unsigned'(sq_s));
  assign closes    = in_i.in_last || (32'(len_new) >= 32'(FRAME_MAX));
  assign full      = (count_q == CW'(ECHO_DEPTH));
  assign push_addr = full ? head_q : wrap_add(head_q, AW'(count_q));
  assign in_i.ready = cmd_i.in_ready;

  // divider step: restoring, one quotient bit per cycle
  logic [LenW:0] rem_sh;
  logic          dge;
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign dge    = rem_sh >= {1'b0, dlen_q};

  // square root step: two radicand bits per cycle
  logic [RmsW+3:0] rem2, trial;
  logic            sge;
  assign rem2  = {srem_q, rad_q[NumW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign sge   = rem2 >= trial;

  // level update
  logic [GainW:0]            inv_rate;
  logic [GainW+RmsW:0]       lvl_acc;
  assign inv_rate = 16'h8000 - {1'b0, rate_q};
  assign lvl_acc  = (GainW+RmsW+1)'(p1_q) + (GainW+RmsW+1)'(inv_rate * level_q)
                  + (GainW+RmsW+1)'(16384);

  // quiet test and echo span
  logic       quiet_now;
  logic [LenW-1:0] span;
  assign quiet_now = {1'b0, root_q, 1'b0} < (RmsW+2)'(level_q);
  assign span      = (32'(cap_len_q) <= 32'(count_q)) ? cap_len_q : LenW'(count_q);

  // per-sample emit math
  logic                  use_echo, speech, emit_last;
  logic [SampleW:0]      abs_c, abs_e;
  logic [GainW-1:0]      g, mul_b;
  logic signed [SampleW-1:0] mul_a;
  logic signed [ProdW:0]  num;
  logic signed [ProdW:0]  q;
  logic signed [SampleW-1:0] v;

  assign use_echo = !quiet_q && (LenW'(idx_q) < n_q);
  assign abs_c    = cap_rd_q[SampleW-1]  ? -{cap_rd_q[SampleW-1], cap_rd_q}
                                         :  {1'b0, cap_rd_q};
  assign abs_e    = fifo_rd_q[SampleW-1] ? -{fifo_rd_q[SampleW-1], fifo_rd_q}
                                         :  {1'b0, fifo_rd_q};
  assign speech   = {1'b0, abs_c, 1'b0} > ({2'b00, abs_e} + {1'b0, abs_e, 1'b0});
  assign g        = speech ? SpeechGain : gain_q;
  assign mul_a    = quiet_q ? cap_rd_q : fifo_rd_q;
  assign mul_b    = quiet_q ? QuietScale : g;
  assign emit_last = (LenW'(idx_q) + LenW'(1)) == cap_len_q;

  always_comb begin
    num = quiet_q ? (ProdW+1)'(prod_q)
                  : ((ProdW+1)'(cap_rd_q) <<< GainW) - (ProdW+1)'(prod_q);
    q = num[ProdW] ? ((num + (ProdW+1)'(32767)) >>> GainW) : (num >>> GainW);
    priority if (!quiet_q && !use_echo) v = cap_rd_q;
    else if (q < -(ProdW+1)'(32768))      v = 16'sh8000;
    else if (q > (ProdW+1)'(32767))       v = 16'sh7fff;
    else                                   v = q[SampleW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GainReset;
      rate_q    <= RateReset;
      head_q    <= '0;
      count_q   <= '0;
      level_q   <= LevelReset;
      cap_len_q <= '0;
      pb_len_q  <= '0;
      cap_e_q   <= '0;
      pb_e_q    <= '0;
      n_q       <= '0;
      quiet_q   <= 1'b0;
      src_cap_q <= 1'b0;
      idx_q     <= '0;
      dcnt_q    <= '0;
      scnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAIN: gain_q <= cfg_data_i;
          CFG_RATE: rate_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (beat) begin
        if (!in_i.cmd) begin
          if (full) head_q  <= wrap_add(head_q, AW'(1));
          else      count_q <= count_q + CW'(1);
          pb_len_q <= closes ? '0 : len_new;
          pb_e_q   <= closes ? '0 : e_new;
        end else begin
          cap_len_q <= len_new;
          cap_e_q   <= closes ? '0 : e_new;
        end
        if (closes) begin
          src_cap_q <= in_i.cmd;
          quiet_q   <= 1'b0;
          n_q       <= '0;
          idx_q     <= '0;
          dcnt_q    <= '0;
        end
      end
      if (cmd_i.div_run)   dcnt_q <= dcnt_q + DivCntW'(1);
      if (cmd_i.sqrt_load) scnt_q <= '0;
      if (cmd_i.sqrt_run)  scnt_q <= scnt_q + SqrtCntW'(1);
      if (cmd_i.lvl_upd && (root_q > RmsActive)) begin
        level_q <= lvl_acc[GainW +: LevelW];
      end
      if (cmd_i.cap_decide) begin
        quiet_q <= quiet_now;
        n_q     <= quiet_now ? '0 : span;
      end
      if (cmd_i.emit_next) idx_q <= idx_q + CIW'(1);
      if (cmd_i.emit_done) begin
        head_q    <= wrap_add(head_q, AW'(n_q));
        count_q   <= count_q - CW'(n_q);
        cap_len_q <= '0;
      end
    end
  end

  // arithmetic payload registers
  always_ff @(posedge clk_i) begin
    if (beat && closes) begin
      num_q  <= {e_new, 16'b0};
      dlen_q <= len_new;
      rem_q  <= '0;
    end else if (cmd_i.div_run) begin
      num_q <= {num_q[NumW-2:0], dge};
      rem_q <= dge ? LenW'(rem_sh - {1'b0, dlen_q}) : rem_sh[LenW-1:0];
    end
    if (cmd_i.sqrt_load) begin
      rad_q  <= num_q;
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_run) begin
      rad_q  <= {rad_q[NumW-3:0], 2'b00};
      root_q <= {root_q[RmsW-2:0], sge};
      srem_q <= sge ? (RmsW+2)'(rem2 - trial) : rem2[RmsW+1:0];
    end
    if (cmd_i.lvl_mul)  p1_q   <= rate_q * root_q;
    if (cmd_i.emit_mul) prod_q <= mul_a * signed'({1'b0, mul_b});
    if (cmd_i.emit_fin) begin
      out_sample_q <= v;
      out_last_q   <= emit_last;
    end
  end

  // echo fifo memory
  always_ff @(posedge clk_i) begin
    if (beat && !in_i.cmd) fifo_mem[push_addr] <= in_i.in_sample;
    if (cmd_i.emit_rd)     fifo_rd_q <= fifo_mem[wrap_add(head_q, AW'(idx_q))];
  end

  // capture frame memory
  always_ff @(posedge clk_i) begin
    if (beat && in_i.cmd) cap_mem[cap_len_q[CIW-1:0]] <= in_i.in_sample;
    if (cmd_i.emit_rd)    cap_rd_q <= cap_mem[idx_q];
  end

  // output beat
  assign out_o.valid      = cmd_i.out_valid;
  assign out_o.out_sample = out_sample_q;
  assign out_o.out_last   = out_last_q;

  // status
  assign sts_o.beat_end   = beat && closes;
  assign sts_o.beat_cap   = in_i.cmd;
  assign sts_o.echo_empty = (count_q == '0);
  assign sts_o.div_done   = (dcnt_q == DivCntW'(NumW));
  assign sts_o.sqrt_done  = (scnt_q == SqrtCntW'(RmsW));
  assign sts_o.src_cap    = src_cap_q;
  assign sts_o.emit_last  = emit_last;
  assign sts_o.out_taken  = out_o.ready;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(ECHO_DEPTH)) else $error("echo count above depth");
  a_emit_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_rd |-> (LenW'(idx_q) < cap_len_q)) else $error("emit index past frame");
  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_done |-> (32'(n_q) <= 32'(count_q))) else $error("pop exceeds fifo fill");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_valid |-> !cmd_i.in_ready) else $error("input open during emit");
`endif

endmodule

/* sv/echo_suppressor_frame_top.sv */
// Frame echo suppressor, top level. Playback beats (cmd 0) fill an echo fifo
// and steer an adaptive level; capture beats (cmd 1) are buffered and, at frame
// end, emitted with echo suppressed. in_i.in_last or the FRAME_MAX-th beat closes
// a frame. Configuration writes (gain, adapt rate) take effect at once; the user
// must see that they are made only while the block is idle, which the block
// itself leaves unchecked.
// Timing: a beat that does not close a frame is taken at once. After a closing
// beat in_i.ready stays low while the frame is processed: restoring division of
// 56 quotient bits and a handoff, then root extraction of 28 digits and a
// decision. A playback frame then updates the level (multiply, then update).
// A capture frame then emits its samples one at a time (read, multiply, finish,
// wait on out_o.ready); in_i.ready rises after the last output beat is taken;
// with an empty fifo division and root are skipped, emission starts next cycle.
// Stall: out_o holds its beat while out_o.ready is low. Reset clears the fifo
// fill, frame lengths and energies and restores the level and registers.
// Depends on esf_pkg, esf_if, esf_ctrl and esf_dp.
module echo_suppressor_frame_top #(
  parameter int ECHO_DEPTH = 4096,
  parameter int FRAME_MAX  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  esf_in_if.sink                         in_i,
  esf_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [esf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [esf_pkg::GainW-1:0]      cfg_data_i
);
  import esf_pkg::*;

  esf_cmd_t cmd;
  esf_sts_t sts;

  // sequencing
  esf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // storage and arithmetic
  esf_dp #(
    .ECHO_DEPTH (ECHO_DEPTH),
    .FRAME_MAX  (FRAME_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
